FILE: hw/rtl/pdd_pkg.sv
`default_nettype none

package pdd_pkg;

    // square geometry and alphabet
    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;
    localparam int LW      = 5;   // letter and cell index width
    localparam int RW      = 3;   // row and column width

    localparam logic [LW-1:0] LETTER_A    = LW'(0);
    localparam logic [LW-1:0] LETTER_I    = LW'(8);
    localparam logic [LW-1:0] LETTER_J    = LW'(9);
    localparam logic [LW-1:0] LETTER_LAST = LW'(LETTERS - 1);
    localparam logic [LW-1:0] NUM_LETTERS = LW'(LETTERS);
    localparam logic [LW-1:0] NUM_CELLS   = LW'(CELLS);

    // item modes
    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_KEY     = 2'd1;
    localparam logic [1:0] MODE_DECRYPT = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic clear;       // empty the square
        logic key;         // try to place the input key letter
        logic latch;       // capture the folded cipher letters
        logic fill_step;   // one step of the remaining-letter sweep
        logic rd_pos;      // read the positions of both letters
        logic rd_pos_in;   // position read addresses from the input item
        logic rd_sq;       // read the two output cells
        logic load_out;    // load the result register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic complete;    // square is full
        logic fill_last;   // sweep is at the last letter
        logic dec_ok;      // both input cipher letters are letters
    } sts_t;

    // row of a cell index below 25
    function automatic logic [RW-1:0] row_of(input logic [LW-1:0] p);
        logic [RW-1:0] r;
        if (p >= LW'(4 * SIDE))      r = RW'(4);
        else if (p >= LW'(3 * SIDE)) r = RW'(3);
        else if (p >= LW'(2 * SIDE)) r = RW'(2);
        else if (p >= LW'(SIDE))     r = RW'(1);
        else                         r = RW'(0);
        return r;
    endfunction

    // cell index from row and column
    function automatic logic [LW-1:0] cell_of(input logic [RW-1:0] r, input logic [RW-1:0] c);
        return LW'({r, 2'b00}) + LW'(r) + LW'(c);
    endfunction

    // one step back with wrap
    function automatic logic [RW-1:0] dec_wrap(input logic [RW-1:0] v);
        return (v == RW'(0)) ? RW'(SIDE - 1) : v - RW'(1);
    endfunction

    // fold cipher J onto I
    function automatic logic [LW-1:0] fold_j(input logic [LW-1:0] l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pdd_ram.sv
`default_nettype none

module pdd_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pdd_ctrl.sv
`default_nettype none

module pdd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [1:0]    mode,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire pdd_pkg::sts_t sts,
    output pdd_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_RDPOS = 3'd2;
    localparam logic [2:0] ST_CALC  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode)
                        pdd_pkg::MODE_CLEAR: cmd.clear = 1'b1;
                        pdd_pkg::MODE_KEY:   cmd.key   = 1'b1;
                        pdd_pkg::MODE_DECRYPT: begin
                            if (sts.dec_ok) begin
                                cmd.latch = 1'b1;
                                if (sts.complete) begin
                                    cmd.rd_pos    = 1'b1;
                                    cmd.rd_pos_in = 1'b1;
                                    state_next    = ST_CALC;
                                end else begin
                                    state_next = ST_FILL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last) begin
                    state_next = ST_RDPOS;
                end
            end
            ST_RDPOS: begin
                cmd.rd_pos = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.rd_sq  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pdd_datapath.sv
`default_nettype none

module pdd_datapath (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [pdd_pkg::LW-1:0]   in_first,
    input  wire logic [pdd_pkg::LW-1:0]   in_second,
    input  wire pdd_pkg::cmd_t            cmd,
    output pdd_pkg::sts_t                 sts,
    output logic      [pdd_pkg::LW-1:0]   plain_first,
    output logic      [pdd_pkg::LW-1:0]   plain_second
);

    localparam int LW = pdd_pkg::LW;
    localparam int RW = pdd_pkg::RW;

    logic [pdd_pkg::LETTERS-1:0] used_reg;
    logic [LW-1:0] fill_reg;
    logic          complete_reg;
    logic [LW-1:0] sweep_reg;
    logic [LW-1:0] a_reg, b_reg;
    logic [LW-1:0] out_a_reg, out_b_reg;

    logic          key_ok, fill_ok, room;
    logic          wr_en;
    logic [LW-1:0] wr_letter;
    logic [LW-1:0] pos_ra, pos_rb, pos_a, pos_b;
    logic [LW-1:0] sq_ra, sq_rb, sq_a, sq_b;
    logic [RW-1:0] ra, ca, rb, cb;

    // placement checks
    assign room    = (fill_reg < pdd_pkg::NUM_CELLS);
    assign key_ok  = !complete_reg && (in_first < pdd_pkg::NUM_LETTERS) &&
                     (in_first != pdd_pkg::LETTER_J) && !used_reg[in_first] && room;
    assign fill_ok = (sweep_reg != pdd_pkg::LETTER_J) && !used_reg[sweep_reg] && room;

    assign wr_en     = (cmd.key && key_ok) || (cmd.fill_step && fill_ok);
    assign wr_letter = cmd.key ? in_first : sweep_reg;

    // status to the controller
    assign sts.complete  = complete_reg;
    assign sts.fill_last = (sweep_reg == pdd_pkg::LETTER_LAST);
    assign sts.dec_ok    = (in_first < pdd_pkg::NUM_LETTERS) &&
                           (in_second < pdd_pkg::NUM_LETTERS);

    // key state and sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= '0;
            fill_reg     <= '0;
            complete_reg <= 1'b0;
            sweep_reg    <= '0;
        end else begin
            if (cmd.clear) begin
                used_reg     <= '0;
                fill_reg     <= '0;
                complete_reg <= 1'b0;
            end else if (wr_en) begin
                used_reg[wr_letter] <= 1'b1;
                fill_reg            <= fill_reg + LW'(1);
            end
            if (cmd.latch) begin
                sweep_reg <= pdd_pkg::LETTER_A;
            end else if (cmd.fill_step) begin
                sweep_reg <= sweep_reg + LW'(1);
                if (sts.fill_last) begin
                    complete_reg <= 1'b1;
                end
            end
        end
    end

    // folded cipher letters
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            a_reg <= pdd_pkg::fold_j(in_first);
            b_reg <= pdd_pkg::fold_j(in_second);
        end
    end

    assign pos_ra = cmd.rd_pos_in ? pdd_pkg::fold_j(in_first)  : a_reg;
    assign pos_rb = cmd.rd_pos_in ? pdd_pkg::fold_j(in_second) : b_reg;

    // cell of each letter
    pdd_ram #(.WIDTH(LW), .DEPTH(pdd_pkg::LETTERS)) u_pos_ram (
        .aclk   (aclk),
        .we     (wr_en),
        .waddr  (wr_letter),
        .wdata  (fill_reg),
        .re     (cmd.rd_pos),
        .raddr0 (pos_ra),
        .raddr1 (pos_rb),
        .rdata0 (pos_a),
        .rdata1 (pos_b)
    );

    // decrypt geometry
    always_comb begin
        ra = pdd_pkg::row_of(pos_a);
        rb = pdd_pkg::row_of(pos_b);
        ca = RW'(pos_a - pdd_pkg::cell_of(ra, RW'(0)));
        cb = RW'(pos_b - pdd_pkg::cell_of(rb, RW'(0)));
        if (ra == rb) begin
            sq_ra = pdd_pkg::cell_of(ra, pdd_pkg::dec_wrap(ca));
            sq_rb = pdd_pkg::cell_of(rb, pdd_pkg::dec_wrap(cb));
        end else if (ca == cb) begin
            sq_ra = pdd_pkg::cell_of(pdd_pkg::dec_wrap(ra), ca);
            sq_rb = pdd_pkg::cell_of(pdd_pkg::dec_wrap(rb), cb);
        end else begin
            sq_ra = pdd_pkg::cell_of(ra, cb);
            sq_rb = pdd_pkg::cell_of(rb, ca);
        end
    end

    // letter in each cell
    pdd_ram #(.WIDTH(LW), .DEPTH(pdd_pkg::CELLS)) u_square_ram (
        .aclk   (aclk),
        .we     (wr_en),
        .waddr  (fill_reg),
        .wdata  (wr_letter),
        .re     (cmd.rd_sq),
        .raddr0 (sq_ra),
        .raddr1 (sq_rb),
        .rdata0 (sq_a),
        .rdata1 (sq_b)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_a_reg <= sq_a;
            out_b_reg <= sq_b;
        end
    end

    assign plain_first  = out_a_reg;
    assign plain_second = out_b_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/playfair_digraph_decrypt.sv
// clear/key items act on accept; a decrypt reads positions then cells into the result
// the first decrypt after loading also sweeps in unused letters and rereads positions
// no new item is taken until a decrypt loads its result; reads use registered ram ports
// synchronous active-low reset empties the key square; ram contents are not cleared
`default_nettype none

module playfair_digraph_decrypt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // letter_first[4:0], letter_second[9:5], zero pad
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // plain_first[4:0], plain_second[9:5], zero pad
);

    localparam int LW = pdd_pkg::LW;

    pdd_pkg::cmd_t cmd;
    pdd_pkg::sts_t sts;
    logic [LW-1:0] plain_first, plain_second;

    pdd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdd_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_first     (s_tdata[LW-1:0]),
        .in_second    (s_tdata[2*LW-1:LW]),
        .cmd          (cmd),
        .sts          (sts),
        .plain_first  (plain_first),
        .plain_second (plain_second)
    );

    // pack the result
    assign m_tdata = {6'b0, plain_second, plain_first};

endmodule

`default_nettype wire
